// ===== rtl/udec_pkg.sv =====
`default_nettype none
package udec_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 3;

  localparam logic [CpW-1:0] ReplReset = 21'h00003F;
  localparam logic [CpW-1:0] Min3Byte  = 21'h000800;
  localparam logic [CpW-1:0] SurrLo    = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi    = 21'h00DFFF;
  localparam logic [CpW-1:0] Min4Byte  = 21'h010000;
  localparam logic [CpW-1:0] MaxScalar = 21'h10FFFF;

  localparam logic [LenW-1:0] FormBad = 3'd0;
  localparam logic [LenW-1:0] Form1   = 3'd1;
  localparam logic [LenW-1:0] Form2   = 3'd2;
  localparam logic [LenW-1:0] Form3   = 3'd3;
  localparam logic [LenW-1:0] Form4   = 3'd4;

  typedef struct packed {
    logic load;
    logic step;
    logic push_last;
  } udec_cmd_t;

  typedef struct packed {
    logic emits;
    logic hold_vld;
    logic out_free;
  } udec_stat_t;

  function automatic logic [LenW-1:0] form_len(input logic [ByteW-1:0] lead);
    logic [LenW-1:0] n;
    if (lead[7] == 1'b0) begin
      n = Form1;
    end else if (lead[7:5] == 3'b110) begin
      n = Form2;
    end else if (lead[7:4] == 4'b1110) begin
      n = Form3;
    end else if (lead[7:3] == 5'b11110) begin
      n = Form4;
    end else begin
      n = FormBad;
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/udec_in_if.sv =====
`default_nettype none
interface udec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       ends_string;

  modport source (output valid, output byte_in, output ends_string, input ready);
  modport sink (input valid, input byte_in, input ends_string, output ready);
endinterface
`default_nettype wire

// ===== rtl/udec_out_if.sv =====
`default_nettype none
interface udec_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        replaced;
  logic        last_in_run;

  modport source (output valid, output code_point, output replaced, output last_in_run,
                  input ready);
  modport sink (input valid, input code_point, input replaced, input last_in_run,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/udec_ctrl.sv =====
`default_nettype none
module udec_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire udec_pkg::udec_stat_t st,
  output udec_pkg::udec_cmd_t       cmd
);

  typedef enum logic {StIdle, StRun} state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      StIdle: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = StRun;
        end
      end
      StRun: begin
        if (!st.emits) begin
          if (!st.hold_vld) begin
            state_nxt = StIdle;
          end else if (st.out_free) begin
            cmd.push_last = 1'b1;
            state_nxt     = StIdle;
          end
        end else if (!st.hold_vld || st.out_free) begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == StIdle);

endmodule
`default_nettype wire

// ===== rtl/udec_dp.sv =====
`default_nettype none
module udec_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire udec_pkg::udec_cmd_t  cmd,
  output udec_pkg::udec_stat_t      st,
  input  wire logic [7:0]           in_byte,
  input  wire logic                 in_ends,
  input  wire logic                 cfg_we,
  input  wire logic [20:0]          cfg_wdata,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [20:0]               out_code_point,
  output logic                      out_replaced,
  output logic                      out_last_in_run
);

  logic [31:0]                     buf_r, buf_nxt;
  logic [udec_pkg::LenW-1:0]       len_r, len_nxt;
  logic                            flush_r, flush_nxt;
  logic [udec_pkg::CpW-1:0]        repl_r;
  logic                            hold_vld_r, hold_vld_nxt;
  logic [udec_pkg::CpW-1:0]        hold_cp_r;
  logic                            hold_rep_r;
  logic                            out_vld_r, out_vld_nxt;
  logic [udec_pkg::CpW-1:0]        out_cp_r;
  logic                            out_rep_r, out_last_r;

  logic [7:0]                      lead;
  logic [udec_pkg::LenW-1:0]       need;
  logic                            bad, ok, emits, res_rep, out_free, push_hold;
  logic [udec_pkg::CpW-1:0]        dec_cp, res_cp;
  logic [udec_pkg::LenW-1:0]       drop_k;

  assign lead = buf_r[7:0];
  assign need = udec_pkg::form_len(lead);

  // A trailing byte that is already present and is not a continuation
  // rejects the lead before the form is complete.
  always_comb begin
    bad = 1'b0;
    for (int i = 1; i < 4; i++) begin
      if (udec_pkg::LenW'(i) < need && udec_pkg::LenW'(i) < len_r &&
          buf_r[8*i+6 +: 2] != 2'b10) begin
        bad = 1'b1;
      end
    end
  end

  always_comb begin
    dec_cp = {14'd0, lead[6:0]};
    ok     = 1'b1;
    case (need)
      udec_pkg::Form2: begin
        dec_cp = {10'd0, lead[4:0], buf_r[13:8]};
        ok     = (lead[4:1] != 4'd0);
      end
      udec_pkg::Form3: begin
        dec_cp = {5'd0, lead[3:0], buf_r[13:8], buf_r[21:16]};
        ok     = (dec_cp >= udec_pkg::Min3Byte) &&
                 !(dec_cp >= udec_pkg::SurrLo && dec_cp <= udec_pkg::SurrHi);
      end
      udec_pkg::Form4: begin
        dec_cp = {lead[2:0], buf_r[13:8], buf_r[21:16], buf_r[29:24]};
        ok     = (dec_cp >= udec_pkg::Min4Byte) && (dec_cp <= udec_pkg::MaxScalar);
      end
      default: begin
        dec_cp = {14'd0, lead[6:0]};
        ok     = 1'b1;
      end
    endcase
  end

  always_comb begin
    emits   = 1'b1;
    res_cp  = repl_r;
    res_rep = 1'b1;
    drop_k  = udec_pkg::Form1;
    if (len_r == '0) begin
      emits = 1'b0;
    end else if (need == udec_pkg::FormBad || bad) begin
      emits = 1'b1;
    end else if (len_r < need) begin
      emits = flush_r;
    end else if (ok) begin
      res_cp  = dec_cp;
      res_rep = 1'b0;
      drop_k  = need;
    end
  end

  assign out_free  = !out_vld_r || out_ready;
  assign push_hold = cmd.step && emits && hold_vld_r;

  always_comb begin
    buf_nxt      = buf_r;
    len_nxt      = len_r;
    flush_nxt    = flush_r;
    hold_vld_nxt = hold_vld_r;
    out_vld_nxt  = out_vld_r;
    if (cmd.load) begin
      if (in_byte == 8'd0) begin
        flush_nxt = 1'b1;
      end else begin
        flush_nxt = in_ends;
        len_nxt   = len_r + 3'd1;
        for (int i = 0; i < 4; i++) begin
          if (len_r[1:0] == 2'(i)) begin
            buf_nxt[8*i +: 8] = in_byte;
          end
        end
      end
    end
    if (cmd.step && emits) begin
      buf_nxt      = buf_r >> {drop_k, 3'b000};
      len_nxt      = len_r - drop_k;
      hold_vld_nxt = 1'b1;
    end
    if (cmd.push_last) begin
      hold_vld_nxt = 1'b0;
    end
    if (push_hold || cmd.push_last) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      flush_r    <= 1'b0;
      repl_r     <= udec_pkg::ReplReset;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      len_r      <= len_nxt;
      flush_r    <= flush_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (cfg_we) begin
        repl_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (cmd.step && emits) begin
      hold_cp_r  <= res_cp;
      hold_rep_r <= res_rep;
    end
    if (push_hold || cmd.push_last) begin
      out_cp_r   <= hold_cp_r;
      out_rep_r  <= hold_rep_r;
      out_last_r <= cmd.push_last;
    end
  end

  assign st.emits    = emits;
  assign st.hold_vld = hold_vld_r;
  assign st.out_free = out_free;

  assign out_valid       = out_vld_r;
  assign out_code_point  = out_cp_r;
  assign out_replaced    = out_rep_r;
  assign out_last_in_run = out_last_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= udec_pkg::Form4)
    else $error("decode window holds more than four bytes");

  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (len_r <= udec_pkg::Form3) && !hold_vld_r)
    else $error("new beat loaded while the window is full or a result is held");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (push_hold || cmd.push_last) |-> out_free)
    else $error("result register overwritten before it was taken");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_last |=> !hold_vld_r && out_vld_r && out_last_r)
    else $error("final result of a beat not released correctly");

endmodule
`default_nettype wire

// ===== rtl/utf8_stream_decoder_top.sv =====
// Streaming UTF-8 decoder: one text byte per input beat, zero to four decoded code
// points per beat on the result channel, the final one of each beat marked by
// last_in_run. Malformed input yields the replacement code (reset value 0x3F,
// written through cfg_we/cfg_wdata; the user is to write it only while idle, which
// the block itself does not enforce) for its first byte, and decoding resumes at
// the next byte; a zero byte or ends_string flushes pending bytes as replacements.
// The controller runs one decode step per cycle over the four-byte window while
// the result channel does not stall, and takes the next beat only when done.
`default_nettype none
module utf8_stream_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  udec_in_if.sink          in_ch,
  udec_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [20:0] cfg_wdata
);

  udec_pkg::udec_cmd_t  cmd;
  udec_pkg::udec_stat_t st;

  udec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  udec_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_byte         (in_ch.byte_in),
    .in_ends         (in_ch.ends_string),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_code_point  (out_ch.code_point),
    .out_replaced    (out_ch.replaced),
    .out_last_in_run (out_ch.last_in_run)
  );

endmodule
`default_nettype wire

// ===== tb/utf8_stream_decoder_top_test.sv =====
`default_nettype none
module utf8_stream_decoder_top_test;

  typedef struct packed {
    logic [udec_pkg::ByteW-1:0] b;
    logic                       ends;
  } text_beat_t;

  typedef struct packed {
    logic [udec_pkg::CpW-1:0] cp;
    logic                     rep;
    logic                     last;
  } code_result_t;

  typedef logic [udec_pkg::ByteW-1:0] byte_seq_t[$];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [udec_pkg::CpW-1:0] cfg_wdata = '0;

  udec_in_if in_ch();
  udec_out_if out_ch();

  utf8_stream_decoder_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  text_beat_t   byte_backlog[$];
  code_result_t expected_cps[$];

  logic [udec_pkg::ByteW-1:0] held_bytes[3] = '{default: '0};
  int unsigned                held_count = 0;
  logic [udec_pkg::CpW-1:0]   repl_code = udec_pkg::ReplReset;

  int unsigned err_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned rx_cyc = 0;
  int unsigned hold_left = 0;
  logic [15:0] rx_pat = 16'hFFFF;
  logic        hold_req = 1'b0;
  logic        hold_started = 1'b0;

  logic [8:0] directed_text[29] = '{
    9'h041, 9'h17F, 9'h0C3, 9'h0A9, 9'h0C1, 9'h0BF, 9'h0E2, 9'h082, 9'h0AC,
    9'h0ED, 9'h0A0, 9'h080, 9'h0F4, 9'h090, 9'h080, 9'h080, 9'h0F0, 9'h09F,
    9'h098, 9'h080, 9'h080, 9'h0FF, 9'h0E2, 9'h041, 9'h0E2, 9'h082, 9'h000,
    9'h0F0, 9'h19F
  };

  logic [udec_pkg::CpW-1:0] repl_values[4] = '{21'h000000, 21'h1FFFFF, 21'h10FFFF,
                                               21'h00FFFD};

  function automatic int unsigned seq_len(input logic [udec_pkg::ByteW-1:0] lead);
    casez (lead)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default: return 0;
    endcase
  endfunction

  function automatic void decode_beat(input logic [udec_pkg::ByteW-1:0] b, input logic ends);
    logic [udec_pkg::ByteW-1:0] win[$];
    code_result_t               res[$];
    int unsigned                need;
    int unsigned                upto;
    logic [udec_pkg::CpW-1:0]   cp;
    logic                       bad;
    logic                       ok;
    for (int i = 0; i < held_count; i++) win.push_back(held_bytes[i]);
    if (b == 8'h00) begin
      repeat (win.size()) res.push_back('{repl_code, 1'b1, 1'b0});
      win.delete();
    end else begin
      win.push_back(b);
      while (win.size() != 0) begin
        need = seq_len(win[0]);
        upto = (need < win.size()) ? need : win.size();
        bad = (need == 0);
        for (int i = 1; i < upto; i++) begin
          if (win[i][7:6] != 2'b10) bad = 1'b1;
        end
        if (bad) begin
          res.push_back('{repl_code, 1'b1, 1'b0});
          void'(win.pop_front());
        end else if (win.size() < need) begin
          break;
        end else begin
          case (need)
            1: begin
              cp = {14'd0, win[0][6:0]};
              ok = 1'b1;
            end
            2: begin
              cp = {10'd0, win[0][4:0], win[1][5:0]};
              ok = cp >= 21'h000080;
            end
            3: begin
              cp = {5'd0, win[0][3:0], win[1][5:0], win[2][5:0]};
              ok = cp >= udec_pkg::Min3Byte &&
                   !(cp >= udec_pkg::SurrLo && cp <= udec_pkg::SurrHi);
            end
            default: begin
              cp = {win[0][2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
              ok = cp >= udec_pkg::Min4Byte && cp <= udec_pkg::MaxScalar;
            end
          endcase
          if (ok) begin
            res.push_back('{cp, 1'b0, 1'b0});
            repeat (need) void'(win.pop_front());
          end else begin
            res.push_back('{repl_code, 1'b1, 1'b0});
            void'(win.pop_front());
          end
        end
      end
      if (ends) begin
        repeat (win.size()) res.push_back('{repl_code, 1'b1, 1'b0});
        win.delete();
      end
    end
    held_count = win.size();
    for (int i = 0; i < 3; i++) held_bytes[i] = (i < held_count) ? win[i] : 8'h00;
    if (res.size() != 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) expected_cps.push_back(res[i]);
  endfunction

  function automatic byte_seq_t utf8_bytes(input logic [udec_pkg::CpW-1:0] cp, input int len);
    byte_seq_t q;
    if (len == 1) begin
      q.push_back({1'b0, cp[6:0]});
    end else begin
      if (len == 2) q.push_back({3'b110, cp[10:6]});
      else if (len == 3) q.push_back({4'b1110, cp[15:12]});
      else q.push_back({5'b11110, cp[20:18]});
      for (int i = len - 2; i >= 0; i--) q.push_back({2'b10, cp[6*i +: 6]});
    end
    return q;
  endfunction

  function automatic logic [udec_pkg::CpW-1:0] scalar_for_len(input int len);
    if (len == 2) return udec_pkg::CpW'($urandom_range(21'h000080, 21'h0007FF));
    if (len == 3) return udec_pkg::CpW'($urandom_range(21'h000800, 21'h00FFFF));
    return udec_pkg::CpW'($urandom_range(udec_pkg::Min4Byte, udec_pkg::MaxScalar));
  endfunction

  // Mostly well-formed characters with random content; the rest are malformed forms
  // and noise. Returns the number of beats queued.
  function automatic int unsigned queue_random_text();
    byte_seq_t                  seq;
    int unsigned                k;
    int                         len;
    int                         pos;
    logic [udec_pkg::ByteW-1:0] b;
    k = $urandom_range(0, 99);
    len = $urandom_range(2, 4);
    if (k < 20) begin
      seq = utf8_bytes(udec_pkg::CpW'($urandom_range(1, 8'h7F)), 1);
    end else if (k < 65) begin
      seq = utf8_bytes(scalar_for_len(len), len);
    end else if (k < 69) begin
      seq = utf8_bytes(udec_pkg::CpW'($urandom_range(0, (len == 2) ? 21'h7F :
                                                     (len == 3) ? 21'h7FF : 21'hFFFF)),
                       len);
    end else if (k < 72) begin
      seq = utf8_bytes(udec_pkg::CpW'($urandom_range(udec_pkg::SurrLo, udec_pkg::SurrHi)),
                       3);
    end else if (k < 75) begin
      seq = utf8_bytes(udec_pkg::CpW'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
    end else if (k < 82) begin
      seq = utf8_bytes(scalar_for_len(len), len);
      repeat ($urandom_range(1, len - 1)) void'(seq.pop_back());
    end else if (k < 87) begin
      seq = utf8_bytes(scalar_for_len(len), len);
      pos = $urandom_range(1, len - 1);
      do b = udec_pkg::ByteW'($urandom_range(1, 255)); while (b[7:6] == 2'b10);
      seq[pos] = b;
    end else if (k < 92) begin
      seq.push_back(udec_pkg::ByteW'($urandom_range(0, 1) ? $urandom_range(8'h80, 8'hBF) :
                                                            $urandom_range(8'hF8, 8'hFF)));
    end else if (k < 97) begin
      seq.push_back(udec_pkg::ByteW'($urandom_range(0, 255)));
    end else begin
      seq.push_back(8'h00);
    end
    foreach (seq[i]) byte_backlog.push_back('{seq[i], $urandom_range(0, 29) == 0});
    return seq.size();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_cnt < 40) $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    err_cnt++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (byte_backlog.size() != 0 || in_ch.valid || expected_cps.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_repl(input logic [udec_pkg::CpW-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    repl_code = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    text_beat_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.byte_in <= '0;
      in_ch.ends_string <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) decode_beat(in_ch.byte_in, in_ch.ends_string);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (byte_backlog.size() != 0) begin
          nxt = byte_backlog.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.byte_in <= nxt.b;
          in_ch.ends_string <= nxt.ends;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    code_result_t want;
    logic         rdy;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_cps.size() == 0) begin
          report_mismatch("result with nothing expected", 32'(out_ch.code_point), 0);
        end else begin
          want = expected_cps.pop_front();
          if (out_ch.code_point !== want.cp)
            report_mismatch("code_point", 32'(out_ch.code_point), 32'(want.cp));
          if (out_ch.replaced !== want.rep)
            report_mismatch("replaced", 32'(out_ch.replaced), 32'(want.rep));
          if (out_ch.last_in_run !== want.last)
            report_mismatch("last_in_run", 32'(out_ch.last_in_run), 32'(want.last));
        end
      end
      rx_cyc++;
      if (rx_cyc % 40 == 0) begin
        rx_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 16'hFFFF));
      end else begin
        rx_pat = {rx_pat[0], rx_pat[15:1]};
      end
      if (hold_req && !hold_started) begin
        hold_started = 1'b1;
        hold_left = 150;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        rdy = rx_pat[0];
      end
      out_ch.ready <= rdy;
    end
  end

  initial begin
    int unsigned queued;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed_text[i]) byte_backlog.push_back('{directed_text[i][7:0],
                                                       directed_text[i][8]});
    wait_idle();
    for (int ph = 0; ph < 5; ph++) begin
      write_repl((ph < 4) ? repl_values[ph] :
                 udec_pkg::CpW'($urandom_range(0, 21'h1FFFFF)));
      if (ph == 1) hold_req = 1'b1;
      queued = 0;
      while (queued < 36) queued += queue_random_text();
      wait_idle();
    end
    if (err_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
